>>> hdl/sorted_alarm_timer_queue_macros.svh
// Assertion macros shared by the sorted alarm timer queue RTL.
`ifndef SORTED_ALARM_TIMER_QUEUE_MACROS_SVH
`define SORTED_ALARM_TIMER_QUEUE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sat_pkg.sv
// Shared constants and types for the sorted alarm timer queue.
package sat_pkg;

  localparam int unsigned SAT_DEPTH     = 16;
  localparam int unsigned SAT_TIME_BITS = 32;
  localparam int unsigned ID_W          = 16;
  localparam int unsigned DELAY_W       = 16;
  localparam int unsigned KIND_W        = 3;
  localparam int unsigned ACTION_W      = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_CANCEL = 2'd1,
    ACT_TICK   = 2'd2
  } sat_action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_EXPIRED   = 3'd0,
    KIND_INSERTED  = 3'd1,
    KIND_FULL      = 3'd2,
    KIND_CANCELLED = 3'd3,
    KIND_NOT_FOUND = 3'd4
  } sat_kind_e;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_SUB = 1'b1
  } sat_op_e;

endpackage

>>> hdl/sat_store.sv
// Single-port-write, single-port-read alarm table memory with registered read.
module sat_store import sat_pkg::*; #(
  parameter int unsigned DEPTH     = SAT_DEPTH,
  parameter int unsigned TIME_BITS = SAT_TIME_BITS,
  localparam int unsigned AW       = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [ID_W-1:0]      wid_i,
  input  logic [TIME_BITS-1:0] wexp_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [ID_W-1:0]      rid_o,
  output logic [TIME_BITS-1:0] rexp_o
);

  logic [ID_W+TIME_BITS-1:0] mem_q [DEPTH];
  logic [ID_W+TIME_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wid_i, wexp_i};
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rid_o  = rdata_q[ID_W+TIME_BITS-1:TIME_BITS];
  assign rexp_o = rdata_q[TIME_BITS-1:0];

endmodule

>>> hdl/sat_alu.sv
// Shared add/subtract unit with wrap-safe order flag and id compare.
module sat_alu import sat_pkg::*; #(
  parameter int unsigned TIME_BITS = SAT_TIME_BITS
) (
  input  sat_op_e              op_i,
  input  logic [TIME_BITS-1:0] a_i,
  input  logic [TIME_BITS-1:0] b_i,
  input  logic [ID_W-1:0]      id_a_i,
  input  logic [ID_W-1:0]      id_b_i,
  output logic [TIME_BITS-1:0] res_o,
  output logic                 nonneg_o,  // a - b is not negative (b at or before a)
  output logic                 id_eq_o
);

  logic [TIME_BITS-1:0] b_eff;

  assign b_eff    = (op_i == OP_SUB) ? ~b_i : b_i;
  assign res_o    = a_i + b_eff + TIME_BITS'(op_i == OP_SUB);
  assign nonneg_o = ~res_o[TIME_BITS-1];
  assign id_eq_o  = (id_a_i == id_b_i);

endmodule

>>> hdl/sorted_alarm_timer_queue.sv
// Sorted alarm timer queue: sequencer, ring-ordered table and result register.
//
// Chan    Dir  Fields (low bit up)
// s_axis  in   tdata: msg_id[15:0] delay_seconds[31:16]; tuser: action[1:0]
// m_axis  out  tdata: msg_id_res[15:0]; tuser: kind[2:0]; tlast: last
//
// One request at a time: s_axis_tready is high only while the sequencer is idle.
// Insert scans for its position, then shifts the tail up and writes the new entry;
//   cancel scans for the id, then shifts later entries down; a refused insert goes straight
//   to the response; tick pops each expired head and stops at an unexpired head or empty table.
// Reset clears count, head and time; table contents are never read before written.
// A full result register stalls the sequencer only when a new result must be loaded.
`include "sorted_alarm_timer_queue_macros.svh"

module sorted_alarm_timer_queue import sat_pkg::*; #(
  parameter int unsigned DEPTH     = SAT_DEPTH,
  parameter int unsigned TIME_BITS = SAT_TIME_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // msg_id[15:0], delay_seconds[31:16]
  input  logic [ACTION_W-1:0] s_axis_tuser,   // action[1:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [ID_W-1:0]     m_axis_tdata,   // msg_id_res[15:0]
  output logic [KIND_W-1:0]   m_axis_tuser,   // kind[2:0]
  output logic                m_axis_tlast
);

  localparam int unsigned IDXW = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);
  localparam int unsigned SUMW = CNTW + 1;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE         = 4'd0;
  localparam logic [3:0] ST_RESP         = 4'd1;
  localparam logic [3:0] ST_INS_SCAN_RD  = 4'd2;
  localparam logic [3:0] ST_INS_SCAN_EV  = 4'd3;
  localparam logic [3:0] ST_INS_SHIFT_RD = 4'd4;
  localparam logic [3:0] ST_INS_SHIFT_WR = 4'd5;
  localparam logic [3:0] ST_INS_PUT      = 4'd6;
  localparam logic [3:0] ST_CAN_SCAN_RD  = 4'd7;
  localparam logic [3:0] ST_CAN_SCAN_EV  = 4'd8;
  localparam logic [3:0] ST_CAN_SHIFT_RD = 4'd9;
  localparam logic [3:0] ST_CAN_SHIFT_WR = 4'd10;
  localparam logic [3:0] ST_TICK_RD      = 4'd11;
  localparam logic [3:0] ST_TICK_EV      = 4'd12;
  localparam logic [3:0] ST_TICK_END     = 4'd13;

  // Logical queue position to physical slot in the ring.
  function automatic logic [IDXW-1:0] slot_of(input logic [IDXW-1:0] head,
                                              input logic [CNTW-1:0] idx);
    logic [SUMW-1:0] sum;
    sum = SUMW'(head) + SUMW'(idx);
    if (sum >= SUMW'(DEPTH)) sum = sum - SUMW'(DEPTH);
    return sum[IDXW-1:0];
  endfunction

  // Control state.
  logic [3:0]           state_q, state_d;
  logic [CNTW-1:0]      count_q, count_d;
  logic [IDXW-1:0]      head_q, head_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic                 pend_q, pend_d;
  logic                 out_valid_q, out_valid_d;

  // Working payload.
  logic [CNTW-1:0]      idx_q, idx_d;
  logic [CNTW-1:0]      pos_q, pos_d;
  logic [ID_W-1:0]      id_q, id_d;
  logic [TIME_BITS-1:0] exp_q, exp_d;
  sat_kind_e            res_kind_q, res_kind_d;
  logic [ID_W-1:0]      pend_id_q, pend_id_d;
  sat_kind_e            out_kind_q, out_kind_d;
  logic [ID_W-1:0]      out_id_q, out_id_d;
  logic                 out_last_q, out_last_d;

  // Table port.
  logic                 mem_we, mem_re;
  logic [CNTW-1:0]      rd_idx, wr_idx;
  logic [IDXW-1:0]      mem_waddr, mem_raddr;
  logic [ID_W-1:0]      mem_wid, mem_rid;
  logic [TIME_BITS-1:0] mem_wexp, mem_rexp;

  // Shared unit.
  sat_op_e              alu_op;
  logic [TIME_BITS-1:0] alu_a, alu_b, alu_res;
  logic                 alu_nonneg, alu_id_eq;

  // Result emission.
  logic                 emit;
  sat_kind_e            emit_kind;
  logic [ID_W-1:0]      emit_id;
  logic                 emit_last;
  logic                 can_emit;

  logic                 accept;
  sat_action_e          req_action;
  logic [ID_W-1:0]      req_id;
  logic [DELAY_W-1:0]   req_delay;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign req_action    = sat_action_e'(s_axis_tuser);
  assign req_id        = s_axis_tdata[ID_W-1:0];
  assign req_delay     = s_axis_tdata[ID_W+DELAY_W-1:ID_W];
  assign can_emit      = !out_valid_q || m_axis_tready;

  assign mem_raddr = slot_of(head_q, rd_idx);
  assign mem_waddr = slot_of(head_q, wr_idx);

  sat_store #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wid_i   (mem_wid),
    .wexp_i  (mem_wexp),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rid_o   (mem_rid),
    .rexp_o  (mem_rexp)
  );

  sat_alu #(
    .TIME_BITS (TIME_BITS)
  ) u_alu (
    .op_i     (alu_op),
    .a_i      (alu_a),
    .b_i      (alu_b),
    .id_a_i   (mem_rid),
    .id_b_i   (id_q),
    .res_o    (alu_res),
    .nonneg_o (alu_nonneg),
    .id_eq_o  (alu_id_eq)
  );

  // Shared unit operand select: expiry or time update while idle, order test in insert scan and tick.
  always_comb begin
    alu_op = OP_ADD;
    alu_a  = now_q;
    alu_b  = (req_action == ACT_TICK) ? TIME_BITS'(1) : TIME_BITS'(req_delay);
    case (state_q)
      ST_INS_SCAN_EV: begin
        // new expiry at or before stored expiry
        alu_op = OP_SUB;
        alu_a  = mem_rexp;
        alu_b  = exp_q;
      end
      ST_TICK_EV: begin
        // head expiry at or before current time
        alu_op = OP_SUB;
        alu_a  = now_q;
        alu_b  = mem_rexp;
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    head_d     = head_q;
    now_d      = now_q;
    pend_d     = pend_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    id_d       = id_q;
    exp_d      = exp_q;
    res_kind_d = res_kind_q;
    pend_id_d  = pend_id_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    rd_idx     = idx_q;
    wr_idx     = idx_q;
    mem_wid    = mem_rid;
    mem_wexp   = mem_rexp;
    emit       = 1'b0;
    emit_kind  = res_kind_q;
    emit_id    = id_q;
    emit_last  = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          id_d  = req_id;
          idx_d = '0;
          case (req_action)
            ACT_INSERT: begin
              exp_d = alu_res;
              if (count_q == CNTW'(DEPTH)) begin
                res_kind_d = KIND_FULL;
                state_d    = ST_RESP;
              end else begin
                state_d = ST_INS_SCAN_RD;
              end
            end
            ACT_CANCEL: state_d = ST_CAN_SCAN_RD;
            ACT_TICK: begin
              now_d   = alu_res;
              state_d = ST_TICK_RD;
            end
            default: state_d = ST_IDLE;  // unused code: dropped
          endcase
        end
      end

      ST_RESP: begin
        if (can_emit) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end

      // Insert: find first entry not earlier than the new one.
      ST_INS_SCAN_RD: begin
        if (idx_q == count_q) begin
          pos_d   = idx_q;
          idx_d   = count_q;
          state_d = ST_INS_SHIFT_RD;
        end else begin
          mem_re  = 1'b1;
          state_d = ST_INS_SCAN_EV;
        end
      end
      ST_INS_SCAN_EV: begin
        if (alu_nonneg) begin
          pos_d   = idx_q;
          idx_d   = count_q;
          state_d = ST_INS_SHIFT_RD;
        end else begin
          idx_d   = idx_q + CNTW'(1);
          state_d = ST_INS_SCAN_RD;
        end
      end
      // Open a hole at pos, moving the tail back one slot from the end.
      ST_INS_SHIFT_RD: begin
        if (idx_q == pos_q) begin
          state_d = ST_INS_PUT;
        end else begin
          mem_re  = 1'b1;
          rd_idx  = idx_q - CNTW'(1);
          state_d = ST_INS_SHIFT_WR;
        end
      end
      ST_INS_SHIFT_WR: begin
        mem_we  = 1'b1;
        idx_d   = idx_q - CNTW'(1);
        state_d = ST_INS_SHIFT_RD;
      end
      ST_INS_PUT: begin
        mem_we     = 1'b1;
        wr_idx     = pos_q;
        mem_wid    = id_q;
        mem_wexp   = exp_q;
        count_d    = count_q + CNTW'(1);
        res_kind_d = KIND_INSERTED;
        state_d    = ST_RESP;
      end

      // Cancel: first matching id, then close the gap.
      ST_CAN_SCAN_RD: begin
        if (idx_q == count_q) begin
          res_kind_d = KIND_NOT_FOUND;
          state_d    = ST_RESP;
        end else begin
          mem_re  = 1'b1;
          state_d = ST_CAN_SCAN_EV;
        end
      end
      ST_CAN_SCAN_EV: begin
        if (alu_id_eq) begin
          state_d = ST_CAN_SHIFT_RD;
        end else begin
          idx_d   = idx_q + CNTW'(1);
          state_d = ST_CAN_SCAN_RD;
        end
      end
      ST_CAN_SHIFT_RD: begin
        if (idx_q + CNTW'(1) == count_q) begin
          count_d    = count_q - CNTW'(1);
          res_kind_d = KIND_CANCELLED;
          state_d    = ST_RESP;
        end else begin
          mem_re  = 1'b1;
          rd_idx  = idx_q + CNTW'(1);
          state_d = ST_CAN_SHIFT_WR;
        end
      end
      ST_CAN_SHIFT_WR: begin
        mem_we  = 1'b1;
        idx_d   = idx_q + CNTW'(1);
        state_d = ST_CAN_SHIFT_RD;
      end

      // Tick: pop expired heads; one result is held back to set last.
      ST_TICK_RD: begin
        if (count_q == '0) begin
          state_d = ST_TICK_END;
        end else begin
          mem_re  = 1'b1;
          rd_idx  = '0;
          state_d = ST_TICK_EV;
        end
      end
      ST_TICK_EV: begin
        if (!alu_nonneg) begin
          state_d = ST_TICK_END;
        end else if (!pend_q || can_emit) begin
          emit      = pend_q;
          emit_kind = KIND_EXPIRED;
          emit_id   = pend_id_q;
          emit_last = 1'b0;
          pend_d    = 1'b1;
          pend_id_d = mem_rid;
          head_d    = (head_q == IDXW'(DEPTH - 1)) ? '0 : head_q + IDXW'(1);
          count_d   = count_q - CNTW'(1);
          state_d   = ST_TICK_RD;
        end
      end
      ST_TICK_END: begin
        if (!pend_q) begin
          state_d = ST_IDLE;
        end else if (can_emit) begin
          emit      = 1'b1;
          emit_kind = KIND_EXPIRED;
          emit_id   = pend_id_q;
          pend_d    = 1'b0;
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_id_d    = out_id_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_kind_d  = emit_kind;
      out_id_d    = emit_id;
      out_last_d  = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      now_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      now_q       <= now_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    id_q       <= id_d;
    exp_q      <= exp_d;
    res_kind_q <= res_kind_d;
    pend_id_q  <= pend_id_d;
    out_kind_q <= out_kind_d;
    out_id_q   <= out_id_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_id_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  // Checks.
  `SAT_ASSERT(a_count_in_range, count_q <= CNTW'(DEPTH), "entry count exceeds depth")
  `SAT_ASSERT_NEXT(a_put_grows, state_q == ST_INS_PUT, count_q == $past(count_q) + CNTW'(1), "insert did not grow count")
  `SAT_ASSERT(a_pend_in_tick, !pend_q || state_q == ST_TICK_RD || state_q == ST_TICK_EV || state_q == ST_TICK_END, "held expiry outside tick")
  `SAT_ASSERT_NEXT(a_full_refused, accept && req_action == ACT_INSERT && count_q == CNTW'(DEPTH), state_q == ST_RESP && res_kind_q == KIND_FULL, "full insert not refused")

endmodule
